// ===== design/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// shared codes, widths and result type of the process table scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TABLE_SLOTS_DEFAULT = 64;

  // fixed part of one slot entry: state, pid, parent valid, channel, killed, exit
  localparam int ENTRY_FIXED_W = 3 + 31 + 1 + 32 + 1 + 32;

  // action codes
  localparam logic [2:0] ACT_SPAWN    = 3'd0;
  localparam logic [2:0] ACT_SCHEDULE = 3'd1;
  localparam logic [2:0] ACT_YIELD    = 3'd2;
  localparam logic [2:0] ACT_SLEEP    = 3'd3;
  localparam logic [2:0] ACT_WAKEUP   = 3'd4;
  localparam logic [2:0] ACT_KILL     = 3'd5;
  localparam logic [2:0] ACT_EXIT     = 3'd6;
  localparam logic [2:0] ACT_WAIT     = 3'd7;

  // slot lifecycle codes
  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] ST_ZOMBIE   = 3'd5;

  // status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FAIL    = 2'd1;
  localparam logic [1:0] STS_BLOCKED = 2'd2;
  localparam logic [1:0] STS_ILLEGAL = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         slot;
    logic [30:0]        pid;
    logic signed [31:0] exit_value;
    logic [6:0]         woken_count;
  } res_t;

endpackage

// ===== design/pts_in_if.sv =====
// ----------------------------------------------------------------------------
// pts_in_if
// request channel: one action beat with its operands
// ----------------------------------------------------------------------------
interface pts_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [5:0]         parent_slot;
  logic               parent_valid;
  logic [31:0]        channel;
  logic [30:0]        target_pid;
  logic signed [31:0] exit_code;

  modport source (output valid, action, parent_slot, parent_valid, channel, target_pid,
                  exit_code, input ready);
  modport sink (input valid, action, parent_slot, parent_valid, channel, target_pid,
                exit_code, output ready);
endinterface

// ===== design/pts_out_if.sv =====
// ----------------------------------------------------------------------------
// pts_out_if
// result channel: one result beat per request
// ----------------------------------------------------------------------------
interface pts_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         slot;
  logic [30:0]        pid;
  logic signed [31:0] exit_value;
  logic [6:0]         woken_count;

  modport source (output valid, status, slot, pid, exit_value, woken_count, input ready);
  modport sink (input valid, status, slot, pid, exit_value, woken_count, output ready);
endinterface

// ===== design/process_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// process_table_scheduler
// process slot table with round-robin scheduling and sleep/wakeup
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  req      in   action, parent_slot, parent_valid, channel, target_pid, exit_code
//  rsp      out  status, slot, pid, exit_value, woken_count
//  cfg      in   cfg_wr_en / cfg_wr_data write init_slot
//
//  a scan reads the slot memory one entry per cycle and ends early on a hit;
//  exit scans the table twice, to re-parent children and then to wake sleepers,
//  and then writes the running slot; a wait scans once and, if it blocks, writes it;
//  yield and sleep, refused actions and an init exit need no scan
//  after reset a clearing pass writes every slot, with req.ready low
//  rsp is a register: the next request is taken while a result waits in it
// ----------------------------------------------------------------------------
module process_table_scheduler #(
  parameter int TABLE_SLOTS = pts_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  pts_in_if.sink     req,
  pts_out_if.source  rsp,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);
  import pts_pkg::*;

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int ENTRY_W = ENTRY_FIXED_W + SLOT_W;

  logic [5:0]         init_slot;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [SLOT_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  // init slot register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      init_slot <= '0;
    end else if (cfg_wr_en) begin
      init_slot <= cfg_wr_data;
    end
  end

  // slot entries live in one memory
  pts_table #(
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer runs each action, walking the table where the action needs it
  pts_seq #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .init_slot (init_slot),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: free when empty or being drained
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp.status      <= res.status;
      rsp.slot        <= res.slot;
      rsp.pid         <= res.pid;
      rsp.exit_value  <= res.exit_value;
      rsp.woken_count <= res.woken_count;
    end
  end
endmodule

// ===== design/pts_table.sv =====
// ----------------------------------------------------------------------------
// pts_table
// slot entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module pts_table #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 106
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/pts_seq.sv =====
// ----------------------------------------------------------------------------
// pts_seq
// action sequencer: scans the slot memory one entry per cycle
// ----------------------------------------------------------------------------
module pts_seq #(
  parameter int TABLE_SLOTS = pts_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  pts_in_if.sink                                    req,
  input  logic [5:0]                                init_slot,
  output logic                                      res_valid,
  input  logic                                      res_ready,
  output pts_pkg::res_t                             res,
  output logic                                      mem_we,
  output logic [$clog2(TABLE_SLOTS)-1:0]            mem_waddr,
  output logic [pts_pkg::ENTRY_FIXED_W+$clog2(TABLE_SLOTS)-1:0] mem_wdata,
  output logic [$clog2(TABLE_SLOTS)-1:0]            mem_raddr,
  input  logic [pts_pkg::ENTRY_FIXED_W+$clog2(TABLE_SLOTS)-1:0] mem_rdata
);
  import pts_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  typedef struct packed {
    logic [2:0]  state;
    logic [30:0] pid;
    logic        pok;
    logic [SW-1:0] parent;
    logic [31:0] chan;
    logic        killed;
    logic [31:0] exit_val;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RDP, S_RDW, S_SCAN, S_FIN, S_RESP
  } state_t;

  state_t        state;
  logic [SW-1:0] rd_addr;
  logic [CW-1:0] issue_cnt;
  logic          pend;
  logic [SW-1:0] pend_addr;
  logic          pass2;
  logic          kids;
  logic          moved;
  logic [6:0]    wcnt;
  entry_t        cur;
  logic          running_ok;
  logic [SW-1:0] running_slot;
  logic [SW-1:0] rr;
  logic [30:0]   next_id;
  logic [2:0]    act;
  logic [5:0]    pslot;
  logic          pvalid;
  logic [31:0]   chan;
  logic [30:0]   tpid;
  logic [31:0]   code;

  entry_t e;
  entry_t scan_wdata;
  entry_t fin_wdata;
  logic   issue;
  logic   hit;
  logic   upd;
  logic   child;
  logic   wake_hit;
  logic   init_in;
  logic   pslot_in;
  logic [30:0] id_inc;

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] a);
    return (a == SW'(TABLE_SLOTS - 1)) ? '0 : a + 1'b1;
  endfunction

  assign e        = entry_t'(mem_rdata);
  assign issue    = (state == S_SCAN) && (issue_cnt != CW'(TABLE_SLOTS));
  assign init_in  = (32'(init_slot) < TABLE_SLOTS);
  assign pslot_in = (32'(pslot) < TABLE_SLOTS);
  assign child    = e.pok && (e.parent == running_slot);
  assign id_inc   = next_id + 31'd1;

  always_comb begin
    wake_hit = 1'b0;
    if (e.state == ST_SLEEPING && !(running_ok && pend_addr == running_slot)) begin
      if (act == ACT_WAKEUP) begin
        wake_hit = (e.chan == chan);
      end else begin
        wake_hit = (moved && init_in && e.chan == 32'(init_slot))
                || (cur.pok && e.chan == 32'(cur.parent));
      end
    end
  end

  // per-entry decision during a scan
  always_comb begin
    hit        = 1'b0;
    upd        = 1'b0;
    scan_wdata = e;
    unique case (act)
      ACT_SPAWN: begin
        hit               = (e.state == ST_UNUSED);
        scan_wdata        = '0;
        scan_wdata.state  = ST_RUNNABLE;
        scan_wdata.pid    = next_id;
        scan_wdata.pok    = pvalid && pslot_in;
        scan_wdata.parent = (pvalid && pslot_in) ? SW'(pslot) : '0;
      end
      ACT_SCHEDULE: begin
        hit              = (e.state == ST_RUNNABLE);
        scan_wdata.state = ST_RUNNING;
      end
      ACT_KILL: begin
        hit               = (e.pid == tpid);
        scan_wdata.killed = 1'b1;
        if (e.state == ST_SLEEPING) begin
          scan_wdata.state = ST_RUNNABLE;
          scan_wdata.chan  = '0;
        end
      end
      ACT_WAIT: begin
        hit        = child && (e.state == ST_ZOMBIE);
        scan_wdata = '0;
      end
      ACT_EXIT: begin
        if (!pass2) begin
          upd = child;
          if (init_in) begin
            scan_wdata.parent = SW'(init_slot);
          end else begin
            scan_wdata.pok    = 1'b0;
            scan_wdata.parent = '0;
          end
        end else begin
          upd              = wake_hit;
          scan_wdata.state = ST_RUNNABLE;
          scan_wdata.chan  = '0;
        end
      end
      ACT_WAKEUP: begin
        upd              = wake_hit;
        scan_wdata.state = ST_RUNNABLE;
        scan_wdata.chan  = '0;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // final write of the running slot
  always_comb begin
    fin_wdata = cur;
    unique case (act)
      ACT_YIELD: fin_wdata.state = ST_RUNNABLE;
      ACT_SLEEP: begin
        fin_wdata.state = ST_SLEEPING;
        fin_wdata.chan  = chan;
      end
      ACT_EXIT: begin
        fin_wdata.state    = ST_ZOMBIE;
        fin_wdata.exit_val = code;
      end
      ACT_WAIT: begin
        fin_wdata.state = ST_SLEEPING;
        fin_wdata.chan  = 32'(running_slot);
      end
      default: fin_wdata = cur;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = scan_wdata;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr;
      mem_wdata = '0;
    end else if (state == S_FIN) begin
      mem_we    = 1'b1;
      mem_waddr = running_slot;
      mem_wdata = fin_wdata;
    end else if (state == S_SCAN && pend && (hit || upd)) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state == S_RDP) ? running_slot : rd_addr;
  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      rd_addr      <= '0;
      issue_cnt    <= '0;
      pend         <= 1'b0;
      running_ok   <= 1'b0;
      running_slot <= '0;
      rr           <= '0;
      next_id      <= 31'd1;
    end else begin
      unique case (state)
        S_CLEAR: begin
          rd_addr <= wrap_inc(rd_addr);
          if (rd_addr == SW'(TABLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            act       <= req.action;
            pslot     <= req.parent_slot;
            pvalid    <= req.parent_valid;
            chan      <= req.channel;
            tpid      <= req.target_pid;
            code      <= req.exit_code;
            res       <= '0;
            pend      <= 1'b0;
            issue_cnt <= '0;
            pass2     <= 1'b0;
            kids      <= 1'b0;
            moved     <= 1'b0;
            wcnt      <= '0;
            rd_addr   <= (req.action == ACT_SCHEDULE) ? rr : '0;
            unique case (req.action)
              ACT_SPAWN, ACT_WAKEUP: state <= S_SCAN;
              ACT_SCHEDULE: begin
                if (running_ok) begin
                  res.status <= STS_FAIL;
                  state      <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              ACT_KILL: begin
                if (req.target_pid == '0) begin
                  res.status <= STS_FAIL;
                  state      <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                if (!running_ok) begin
                  res.status <= STS_ILLEGAL;
                  state      <= S_RESP;
                end else begin
                  state <= S_RDP;
                end
              end
            endcase
          end
        end
        S_RDP: state <= S_RDW;
        S_RDW: begin
          cur      <= e;
          res.slot <= 6'(running_slot);
          res.pid  <= e.pid;
          unique case (act)
            ACT_EXIT: begin
              if (32'(running_slot) == 32'(init_slot)) begin
                res.status <= STS_ILLEGAL;
                state      <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end
            ACT_WAIT: state <= S_SCAN;
            default:  state <= S_FIN;
          endcase
        end
        S_SCAN: begin
          if (issue) begin
            rd_addr   <= wrap_inc(rd_addr);
            issue_cnt <= issue_cnt + 1'b1;
          end
          pend      <= issue;
          pend_addr <= rd_addr;
          if (pend) begin
            if (upd) begin
              wcnt <= wcnt + 7'd1;
            end
            if (act == ACT_EXIT && !pass2 && child) begin
              moved <= 1'b1;
              if (pend_addr == running_slot) begin
                cur.pok    <= scan_wdata.pok;
                cur.parent <= scan_wdata.parent;
              end
            end
            if (act == ACT_WAIT && child) begin
              kids <= 1'b1;
            end
            if (hit) begin
              res.slot <= 6'(pend_addr);
              state    <= S_RESP;
              unique case (act)
                ACT_SPAWN: begin
                  res.pid <= next_id;
                  next_id <= (id_inc == '0) ? 31'd1 : id_inc;
                end
                ACT_SCHEDULE: begin
                  res.pid      <= e.pid;
                  running_ok   <= 1'b1;
                  running_slot <= pend_addr;
                  rr           <= wrap_inc(pend_addr);
                end
                ACT_WAIT: begin
                  res.pid        <= e.pid;
                  res.exit_value <= e.exit_val;
                end
                default: res.pid <= tpid;
              endcase
            end
          end else if (issue_cnt == CW'(TABLE_SLOTS)) begin
            unique case (act)
              ACT_WAKEUP: begin
                res.woken_count <= wcnt;
                state           <= S_RESP;
              end
              ACT_EXIT: begin
                if (!pass2) begin
                  pass2     <= 1'b1;
                  issue_cnt <= '0;
                  rd_addr   <= '0;
                end else begin
                  state <= S_FIN;
                end
              end
              ACT_WAIT: begin
                if (!kids || cur.killed) begin
                  res.status <= STS_FAIL;
                  state      <= S_RESP;
                end else begin
                  state <= S_FIN;
                end
              end
              default: begin
                res.status <= STS_FAIL;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_FIN: begin
          running_ok <= 1'b0;
          res.status <= (act == ACT_WAIT) ? STS_BLOCKED : STS_OK;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
